### hdl/bdar_pkg.sv
package bdar_pkg;

    // Default width of the press and repeat tick counters.
    localparam int CNT_BITS_DEF = 32;

    // All timing registers are 16-bit tick counts.
    localparam int TICK_W = 16;
    localparam int APB_DW = 32;
    localparam int ADDR_W = 5;

    typedef logic [TICK_W-1:0] t_tick;

    // Register reset values, in 1 ms ticks.
    localparam t_tick DEBOUNCE_RST  = 16'd20;
    localparam t_tick IMPULSE_RST   = 16'd250;
    localparam t_tick FASTEN_ST_RST = 16'd2000;
    localparam t_tick FASTEN_TH_RST = 16'd100;
    localparam t_tick FASTEN_FL_RST = 16'd50;

    // Query kinds; the codes above OP_NONE also make no query.
    typedef enum logic [2:0] {
        OP_SIMPLE     = 3'd0,
        OP_IMPULSE    = 3'd1,
        OP_CONTINUOUS = 3'd2,
        OP_FASTEN     = 3'd3,
        OP_NONE       = 3'd4
    } t_op;

    // Register index, taken from the word address of the configuration port.
    typedef enum logic [2:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_IMPULSE   = 3'd1,
        REG_FASTEN_ST = 3'd2,
        REG_FASTEN_TH = 3'd3,
        REG_FASTEN_FL = 3'd4
    } t_reg;

    typedef struct packed {
        logic [2:0] op;
        logic       raw_pushed;
    } t_in_beat;

    typedef struct packed {
        logic fire;
        logic pushed_level;
        logic released_flag;
    } t_out_beat;

    // A period of zero behaves as a period of one tick.
    function automatic t_tick at_least_one(input t_tick v);
        return (v == '0) ? t_tick'(1) : v;
    endfunction

endpackage

### hdl/bdar_div.sv
module bdar_div #(
    parameter int DIV_BITS = bdar_pkg::CNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  bdar_pkg::t_tick     i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output logic [DIV_BITS-1:0] o_quot,
    output bdar_pkg::t_tick     o_rem
);
    import bdar_pkg::*;

    localparam int CW = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] r_acc;
    t_tick               r_rem;
    t_tick               r_den;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [TICK_W:0]     trial;
    logic                take;
    t_tick               n_rem;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        trial = {r_rem, r_acc[DIV_BITS-1]};
        take  = trial >= {1'b0, r_den};
        n_rem = take ? TICK_W'(trial - {1'b0, r_den}) : trial[TICK_W-1:0];
    end

    // Step counter and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out on the left while quotient bits enter on the right.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[DIV_BITS-2:0], take};
            r_rem <= n_rem;
        end
    end

    // The result cycle counts as busy so that the owner can store it first.
    assign o_busy = r_busy | r_done;
    assign o_done = r_done;
    assign o_quot = r_acc;
    assign o_rem  = r_rem;

endmodule

### hdl/button_debounce_autorepeat_unit.sv
// Result beats are registered in the output register.
// Throughput: one tick per cycle while the skid stage is empty; after a fastening start or
// repeat whose new period is not settled directly, input stalls for the restoring division.
// A one-beat skid stage lets ticks enter while a result waits on a stalled output.
// Reset is synchronous and active low: control state clears and registers take their defaults.
module button_debounce_autorepeat_unit #(
    parameter int COUNT_BITS = bdar_pkg::CNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  bdar_pkg::t_in_beat           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bdar_pkg::t_out_beat          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdar_pkg::ADDR_W-1:0]  paddr,
    input  logic [bdar_pkg::APB_DW-1:0]  pwdata,
    output logic [bdar_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import bdar_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Configuration registers.
    t_tick r_cfg_deb, r_cfg_imp, r_cfg_fst, r_cfg_fth, r_cfg_ffl;
    logic [2:0] cfg_idx;

    // Debounce and query state.
    logic                  r_deb, r_rel;
    logic [COUNT_BITS-1:0] r_pe;
    logic                  r_sa, r_ia, r_ca, r_fa, r_mc, r_iph;
    t_tick                 r_wc;
    logic                  r_wp;
    // Fastening reference count, kept with its quotient and remainder by the period.
    logic [COUNT_BITS-1:0] r_fx, r_fq;
    t_tick                 r_fr, r_fp;

    logic                  n_deb, n_rel;
    logic [COUNT_BITS-1:0] n_pe;
    logic                  n_sa, n_ia, n_ca, n_fa, n_mc, n_iph;
    t_tick                 n_wc;
    logic                  n_wp;
    logic [COUNT_BITS-1:0] n_fx, n_fq;
    t_tick                 n_fr, n_fp;
    logic                  n_fire;

    logic                  div_start, n_div_start;
    logic [COUNT_BITS-1:0] n_div_num;
    t_tick                 n_div_den;
    logic                  div_busy, div_done;
    logic [COUNT_BITS-1:0] div_quot;
    t_tick                 div_rem;

    // Output register and skid stage.
    logic                  r_out_valid, r_skid_valid;
    t_out_beat             r_out, r_skid, n_beat;
    logic                  in_acc, out_taken;

    t_tick                 p_eff, imp_eff, p_next, shrunk, p_start;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[ADDR_W-1:2];
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_taken = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid || div_busy;
    assign div_start  = in_acc && n_div_start;

    // Register writes on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_deb <= DEBOUNCE_RST;
            r_cfg_imp <= IMPULSE_RST;
            r_cfg_fst <= FASTEN_ST_RST;
            r_cfg_fth <= FASTEN_TH_RST;
            r_cfg_ffl <= FASTEN_FL_RST;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_DEBOUNCE:  r_cfg_deb <= pwdata[TICK_W-1:0];
                REG_IMPULSE:   r_cfg_imp <= pwdata[TICK_W-1:0];
                REG_FASTEN_ST: r_cfg_fst <= pwdata[TICK_W-1:0];
                REG_FASTEN_TH: r_cfg_fth <= pwdata[TICK_W-1:0];
                REG_FASTEN_FL: r_cfg_ffl <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (cfg_idx)
            REG_DEBOUNCE:  prdata = APB_DW'(r_cfg_deb);
            REG_IMPULSE:   prdata = APB_DW'(r_cfg_imp);
            REG_FASTEN_ST: prdata = APB_DW'(r_cfg_fst);
            REG_FASTEN_TH: prdata = APB_DW'(r_cfg_fth);
            REG_FASTEN_FL: prdata = APB_DW'(r_cfg_ffl);
            default:       prdata = '0;
        endcase
    end

    // Period arithmetic that depends on registers only.
    always_comb begin
        p_eff   = at_least_one(r_fp);
        imp_eff = at_least_one(r_cfg_imp);
        p_start = at_least_one(r_cfg_fst);
        shrunk  = p_eff - (p_eff >> 2);
        p_next  = (shrunk < r_cfg_fth) ? at_least_one(r_cfg_ffl) : at_least_one(shrunk);
    end

    // One tick: counters advance, then debouncing, then the query.
    always_comb begin
        logic                  pe_can, x_can, wrap, mc;
        logic [COUNT_BITS-1:0] pe_adv, x_adv, q_adv;
        t_tick                 wc_p1, wc_adv, rem_adv;
        logic                  wp_adv;
        logic [TICK_W:0]       rem_inc;

        // Press counter and impulse window.
        pe_can = r_pe != CNT_MAX;
        pe_adv = r_pe;
        wc_adv = r_wc;
        wp_adv = r_wp;
        wc_p1  = r_wc + t_tick'(1);
        if (pe_can) begin
            pe_adv = r_pe + COUNT_BITS'(1);
            if (wc_p1 >= imp_eff) begin
                wc_adv = '0;
                wp_adv = !r_wp;
            end else begin
                wc_adv = wc_p1;
            end
        end

        // Fastening reference count with its quotient and remainder.
        x_can   = r_fx != CNT_MAX;
        rem_inc = {1'b0, r_fr} + (TICK_W + 1)'(1);
        wrap    = rem_inc >= {1'b0, p_eff};
        x_adv   = r_fx;
        q_adv   = r_fq;
        rem_adv = r_fr;
        if (x_can) begin
            x_adv = r_fx + COUNT_BITS'(1);
            if (wrap) begin
                rem_adv = '0;
                q_adv   = r_fq + COUNT_BITS'(1);
            end else begin
                rem_adv = rem_inc[TICK_W-1:0];
            end
        end

        // Debouncing: a rising raw level restarts the press, a low level past the debounce ends it.
        n_pe  = pe_adv;
        n_wc  = wc_adv;
        n_wp  = wp_adv;
        n_deb = r_deb;
        if (i_in_data.raw_pushed) begin
            if (!r_deb) begin
                n_deb = 1'b1;
                n_pe  = '0;
                n_wc  = '0;
                n_wp  = 1'b0;
            end
        end else begin
            n_deb = r_deb && (pe_adv <= COUNT_BITS'(r_cfg_deb));
        end
        n_rel = r_rel || (r_deb && !n_deb);

        // Query.
        n_sa = r_sa;
        n_ia = r_ia;
        n_ca = r_ca;
        n_fa = r_fa;
        n_iph = r_iph;
        n_fx = x_adv;
        n_fq = q_adv;
        n_fr = rem_adv;
        n_fp = r_fp;
        n_fire = 1'b0;
        n_div_start = 1'b0;
        n_div_num = '0;
        n_div_den = p_eff;
        mc = r_mc;
        case (i_in_data.op)
            OP_SIMPLE: begin
                if (r_ia || r_ca || r_fa) begin
                    n_ia = 1'b0;
                    n_ca = 1'b0;
                    n_fa = 1'b0;
                    mc   = 1'b1;
                end
                if (mc) begin
                    n_sa = 1'b1;
                    mc   = 1'b0;
                end else if (n_deb) begin
                    if (!r_sa) begin
                        n_sa   = 1'b1;
                        n_fire = 1'b1;
                    end
                end else begin
                    n_sa = 1'b0;
                end
            end
            OP_IMPULSE: begin
                if (r_sa || r_ca || r_fa) begin
                    n_sa = 1'b0;
                    mc   = 1'b1;
                end
                n_ca = 1'b0;
                n_fa = 1'b0;
                if (mc) begin
                    if (!n_deb) begin
                        mc = 1'b0;
                    end
                end else if (!n_deb) begin
                    n_ia = 1'b0;
                end else if (!r_ia) begin
                    n_ia   = 1'b1;
                    n_iph  = 1'b0;
                    n_fire = 1'b1;
                end else if (n_wp != r_iph) begin
                    n_iph  = !r_iph;
                    n_fire = 1'b1;
                end
            end
            OP_CONTINUOUS: begin
                if (r_sa || r_ia || r_fa) begin
                    n_sa = 1'b0;
                    mc   = 1'b1;
                end
                n_ia = 1'b0;
                n_fa = 1'b0;
                if (mc) begin
                    if (!n_deb) begin
                        mc = 1'b0;
                    end
                end else begin
                    n_ca   = n_deb;
                    n_fire = n_deb;
                end
            end
            OP_FASTEN: begin
                if (r_sa || r_ia || r_ca) begin
                    n_sa = 1'b0;
                    mc   = 1'b1;
                end
                n_ia = 1'b0;
                n_ca = 1'b0;
                if (mc) begin
                    if (!n_deb) begin
                        mc = 1'b0;
                    end
                end else if (!n_deb) begin
                    n_fa = 1'b0;
                end else if (!r_fa) begin
                    // First activation: reference restarts at the press count.
                    n_fa   = 1'b1;
                    n_fire = 1'b1;
                    n_fp   = p_start;
                    n_fx   = n_pe;
                    if (n_pe < COUNT_BITS'(p_start)) begin
                        n_fq = '0;
                        n_fr = n_pe[TICK_W-1:0];
                    end else begin
                        n_div_start = 1'b1;
                        n_div_num   = n_pe;
                        n_div_den   = p_start;
                    end
                end else if (q_adv[0]) begin
                    // Odd quotient: step the reference one period and shrink the period.
                    n_fire = 1'b1;
                    n_fp   = p_next;
                    n_fx   = x_adv - COUNT_BITS'(p_eff);
                    if ((q_adv == COUNT_BITS'(1)) && (rem_adv < p_next)) begin
                        n_fq = '0;
                        n_fr = rem_adv;
                    end else begin
                        n_fq        = q_adv - COUNT_BITS'(1);
                        n_div_start = 1'b1;
                        n_div_num   = x_adv - COUNT_BITS'(p_eff);
                        n_div_den   = p_next;
                    end
                end
            end
            default: ;
        endcase
        n_mc = mc;

        n_beat.fire          = n_fire;
        n_beat.pushed_level  = n_deb;
        n_beat.released_flag = n_rel;
    end

    // State update on each accepted tick; the divider settles quotient and remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb <= 1'b0;
            r_rel <= 1'b0;
            r_pe  <= '0;
            r_sa  <= 1'b0;
            r_ia  <= 1'b0;
            r_ca  <= 1'b0;
            r_fa  <= 1'b0;
            r_mc  <= 1'b0;
            r_iph <= 1'b0;
            r_wc  <= '0;
            r_wp  <= 1'b0;
            r_fx  <= '0;
            r_fq  <= '0;
            r_fr  <= '0;
            r_fp  <= '0;
        end else if (in_acc) begin
            r_deb <= n_deb;
            r_rel <= n_rel;
            r_pe  <= n_pe;
            r_sa  <= n_sa;
            r_ia  <= n_ia;
            r_ca  <= n_ca;
            r_fa  <= n_fa;
            r_mc  <= n_mc;
            r_iph <= n_iph;
            r_wc  <= n_wc;
            r_wp  <= n_wp;
            r_fx  <= n_fx;
            r_fq  <= n_fq;
            r_fr  <= n_fr;
            r_fp  <= n_fp;
        end else if (div_done) begin
            r_fq <= div_quot;
            r_fr <= div_rem;
        end
    end

    // Restoring divider for the reference count against a new period.
    bdar_div #(
        .DIV_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_div_num),
        .i_divisor  (n_div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Output register valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_taken || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output and skid payload.
    always_ff @(posedge i_clk) begin
        if (out_taken || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_beat;
            end
        end else if (in_acc) begin
            r_skid <= n_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // At most one query kind owns the button at a time.
    a_one_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_sa, r_ia, r_ca, r_fa}))
        else $error("more than one query kind active");

    // The released flag never clears outside reset.
    a_rel_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel |=> r_rel)
        else $error("released flag cleared");

    // Once settled, the fastening remainder lies below the period.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !div_busy |-> (r_fr < p_eff))
        else $error("fastening remainder out of range");

    // A beat waits in the skid stage only behind a full output register.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a beat ahead of the output register");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bdar_pkg::*;

    localparam int CNT_W = CNT_BITS_DEF;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;
    // A fastening repeat may keep the divider busy after its beat has left.
    localparam int SETTLE_CYCLES = CNT_W + 9;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD = 300;

    // Query codes above OP_NONE that the block must treat as no query.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;

    // Every input of the block starts from a known value.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    t_in_beat            i_in_data = '0;
    logic                i_out_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out_beat           o_out_data;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Predicted reports, oldest first.
    t_out_beat predicted_reports[$];
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Idling rates in percent and the long receiver hold-off request.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    // Register copies used by the predictor.
    t_tick cfg_debounce, cfg_impulse, cfg_fasten_start, cfg_fasten_thresh, cfg_fasten_floor;

    // Predictor state.
    logic             deb_level, deb_prev, released_seen;
    logic [CNT_W-1:0] press_ticks;
    logic             simple_on, impulse_on, continuous_on, fasten_on;
    logic             kind_switch, impulse_phase, window_parity;
    t_tick            window_ticks;
    logic [CNT_W-1:0] since_ref;
    t_tick            fasten_period;

    button_debounce_autorepeat_unit #(
        .COUNT_BITS(CNT_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // A period of zero counts as one tick.
    function automatic t_tick nonzero_period(input t_tick v);
        return (v == '0) ? t_tick'(1) : v;
    endfunction

    // Shared switch handling of the repeating query kinds; returns 1 while suppressed.
    function automatic logic kind_switched(input logic other_a, input logic other_b,
                                           input logic other_c);
        if (other_a || other_b || other_c) begin
            simple_on = 1'b0;
            kind_switch = 1'b1;
        end
        if (kind_switch) begin
            if (!deb_level) begin
                kind_switch = 1'b0;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic reset_predictor();
        cfg_debounce = DEBOUNCE_RST;
        cfg_impulse = IMPULSE_RST;
        cfg_fasten_start = FASTEN_ST_RST;
        cfg_fasten_thresh = FASTEN_TH_RST;
        cfg_fasten_floor = FASTEN_FL_RST;
        deb_level = 1'b0;
        deb_prev = 1'b0;
        released_seen = 1'b0;
        press_ticks = '0;
        simple_on = 1'b0;
        impulse_on = 1'b0;
        continuous_on = 1'b0;
        fasten_on = 1'b0;
        kind_switch = 1'b0;
        impulse_phase = 1'b0;
        window_parity = 1'b0;
        window_ticks = '0;
        since_ref = '0;
        fasten_period = '0;
    endtask

    // One tick: counters advance, then debouncing, then the query.
    function automatic t_out_beat next_button_report(input t_in_beat b);
        t_out_beat r;
        t_tick p;
        t_tick shrunk;
        logic [CNT_W-1:0] windows;
        logic sup;
        r = '0;

        // Tick counters; the impulse window freezes with the press counter.
        if (press_ticks != CNT_SAT) begin
            press_ticks++;
            window_ticks++;
            if (window_ticks >= nonzero_period(cfg_impulse)) begin
                window_ticks = '0;
                window_parity = ~window_parity;
            end
        end
        if (since_ref != CNT_SAT) begin
            since_ref++;
        end

        // Debounce: a rising raw level starts a press, the hold keeps it up.
        if (b.raw_pushed) begin
            if (!deb_level) begin
                deb_level = 1'b1;
                press_ticks = '0;
                window_ticks = '0;
                window_parity = 1'b0;
            end
        end else begin
            deb_level = deb_level && (press_ticks <= CNT_W'(cfg_debounce));
        end
        if (deb_prev && !deb_level) begin
            released_seen = 1'b1;
        end
        deb_prev = deb_level;

        // Query evaluation.
        case (b.op)
            OP_SIMPLE: begin
                if (impulse_on || continuous_on || fasten_on) begin
                    impulse_on = 1'b0;
                    continuous_on = 1'b0;
                    fasten_on = 1'b0;
                    kind_switch = 1'b1;
                end
                if (kind_switch) begin
                    simple_on = 1'b1;
                    kind_switch = 1'b0;
                end else if (deb_level) begin
                    r.fire = !simple_on;
                    simple_on = 1'b1;
                end else begin
                    simple_on = 1'b0;
                end
            end
            OP_IMPULSE: begin
                sup = kind_switched(simple_on, continuous_on, fasten_on);
                continuous_on = 1'b0;
                fasten_on = 1'b0;
                if (!sup) begin
                    if (!deb_level) begin
                        impulse_on = 1'b0;
                    end else if (!impulse_on) begin
                        impulse_on = 1'b1;
                        impulse_phase = 1'b0;
                        r.fire = 1'b1;
                    end else if (window_parity != impulse_phase) begin
                        impulse_phase = ~impulse_phase;
                        r.fire = 1'b1;
                    end
                end
            end
            OP_CONTINUOUS: begin
                sup = kind_switched(simple_on, impulse_on, fasten_on);
                impulse_on = 1'b0;
                fasten_on = 1'b0;
                if (!sup) begin
                    continuous_on = deb_level;
                    r.fire = deb_level;
                end
            end
            OP_FASTEN: begin
                sup = kind_switched(simple_on, impulse_on, continuous_on);
                impulse_on = 1'b0;
                continuous_on = 1'b0;
                if (!sup) begin
                    if (!deb_level) begin
                        fasten_on = 1'b0;
                    end else if (!fasten_on) begin
                        fasten_on = 1'b1;
                        fasten_period = nonzero_period(cfg_fasten_start);
                        since_ref = press_ticks;
                        r.fire = 1'b1;
                    end else begin
                        // Fire on an odd number of elapsed periods, then shrink the period.
                        p = nonzero_period(fasten_period);
                        windows = since_ref / p;
                        if (windows[0]) begin
                            shrunk = p - p / 16'd4;
                            since_ref = since_ref - p;
                            if (shrunk < cfg_fasten_thresh) begin
                                fasten_period = nonzero_period(cfg_fasten_floor);
                            end else begin
                                fasten_period = nonzero_period(shrunk);
                            end
                            r.fire = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        r.pushed_level = deb_level;
        r.released_flag = released_seen;
        return r;
    endfunction

    // Receiver: random stalls plus an optional long hold-off counted here.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end else if (hold_left != 0) begin
            hold_left--;
        end
        i_out_stall <= (hold_left != 0) ||
                       (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Result checker: each accepted beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_reports.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %b",
                         $time, o_out_data);
                mismatch_count++;
            end else begin
                want = predicted_reports.pop_front();
                if (o_out_data.fire !== want.fire) begin
                    $display("%0t: fire mismatch, expected %b actual %b",
                             $time, want.fire, o_out_data.fire);
                    mismatch_count++;
                end
                if (o_out_data.pushed_level !== want.pushed_level) begin
                    $display("%0t: pushed_level mismatch, expected %b actual %b",
                             $time, want.pushed_level, o_out_data.pushed_level);
                    mismatch_count++;
                end
                if (o_out_data.released_flag !== want.released_flag) begin
                    $display("%0t: released_flag mismatch, expected %b actual %b",
                             $time, want.released_flag, o_out_data.released_flag);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("button_debounce_autorepeat_unit verification failed");
        $finish;
    end

    // Sends one tick beat, with an optional random gap before it.
    task automatic send_tick(input logic [2:0] op, input logic raw);
        t_in_beat b;
        b.op = op;
        b.raw_pushed = raw;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        predicted_reports.push_back(next_button_report(b));
    endtask

    // Sender pauses until every predicted report has been checked.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (predicted_reports.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Setup and access cycle of one register write; psel stays high for the next one.
    task automatic write_reg(input t_reg idx, input t_tick value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DEBOUNCE:  cfg_debounce = value;
            REG_IMPULSE:   cfg_impulse = value;
            REG_FASTEN_ST: cfg_fasten_start = value;
            REG_FASTEN_TH: cfg_fasten_thresh = value;
            REG_FASTEN_FL: cfg_fasten_floor = value;
            default: begin
            end
        endcase
    endtask

    // Writes all timing registers once the block has gone idle.
    task automatic configure(input t_tick deb, input t_tick imp, input t_tick fst,
                             input t_tick fth, input t_tick ffl);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_IMPULSE, imp);
        write_reg(REG_FASTEN_ST, fst);
        write_reg(REG_FASTEN_TH, fth);
        write_reg(REG_FASTEN_FL, ffl);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Press and release sequences with random content, contact bounce and stray queries.
    task automatic run_presses(input int n_ticks, input int max_hold);
        int done_ticks;
        int hi_len;
        int lo_len;
        logic [2:0] kind;
        logic [2:0] op;
        logic raw;
        done_ticks = 0;
        while (done_ticks < n_ticks) begin
            kind = ($urandom_range(99) < 85) ? 3'($urandom_range(3)) : 3'($urandom_range(7, 4));
            hi_len = $urandom_range(max_hold, 1);
            lo_len = $urandom_range(25, 1);
            for (int t = 0; t < hi_len + lo_len; t++) begin
                raw = (t < hi_len);
                if ($urandom_range(99) < 8) begin
                    raw = ~raw;
                end
                op = kind;
                if ($urandom_range(99) < 10) begin
                    op = 3'($urandom_range(7));
                end
                send_tick(op, raw);
            end
            done_ticks += hi_len + lo_len;
        end
    endtask

    // Hand-picked ticks: hold after reset, each query kind, switching and unused codes.
    task automatic test_directed();
        send_tick(OP_NONE, 1'b0);
        send_tick(OP_SIMPLE, 1'b0);
        configure(16'd2, 16'd2, 16'd4, 16'd4, 16'd1);
        send_tick(OP_SIMPLE, 1'b1);
        send_tick(OP_SIMPLE, 1'b1);
        send_tick(OP_SIMPLE, 1'b0);
        send_tick(OP_SIMPLE, 1'b0);
        repeat (4) send_tick(OP_IMPULSE, 1'b1);
        send_tick(OP_CONTINUOUS, 1'b1);
        send_tick(OP_CONTINUOUS, 1'b0);
        send_tick(OP_CONTINUOUS, 1'b1);
        send_tick(OP_CONTINUOUS, 1'b1);
        repeat (3) send_tick(OP_FASTEN, 1'b0);
        repeat (6) send_tick(OP_FASTEN, 1'b1);
        send_tick(OP_SPARE_FIRST, 1'b1);
        send_tick(OP_SPARE_MID, 1'b0);
        send_tick(OP_SPARE_LAST, 1'b1);
        send_tick(OP_NONE, 1'b0);
    endtask

    // Short periods where fastening shrinks step by step down to the floor.
    task automatic test_typical_periods();
        configure(16'd3, 16'd4, 16'd16, 16'd6, 16'd2);
        set_idling(0, 0);
        run_presses(250, 40);
    endtask

    // Smallest legal settings with an idle sender.
    task automatic test_minimum_periods();
        configure(16'd0, 16'd1, 16'd1, 16'd0, 16'd1);
        set_idling(45, 0);
        run_presses(200, 30);
    endtask

    // Zero periods act as one tick; the threshold forces the floor at once.
    task automatic test_zero_periods();
        configure(16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd0);
        set_idling(0, 45);
        run_presses(200, 30);
    endtask

    // Largest settings: the hold and every period outlast the phase.
    task automatic test_maximum_periods();
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_idling(7, 7);
        run_presses(120, 30);
    endtask

    // Random small settings, zeros included, across the idling phases.
    task automatic test_random_settings();
        for (int ph = 0; ph < 3; ph++) begin
            configure(t_tick'($urandom_range(8)), t_tick'($urandom_range(6)),
                      t_tick'($urandom_range(20)), t_tick'($urandom_range(10)),
                      t_tick'($urandom_range(4)));
            case (ph)
                0: set_idling(45, 45);
                1: set_idling(0, 0);
                default: set_idling(7, 7);
            endcase
            run_presses(120, 40);
        end
    endtask

    // Output held off for a long stretch while ticks keep coming, then a full drain.
    task automatic test_backpressure();
        configure(16'd3, 16'd4, 16'd12, 16'd5, 16'd2);
        set_idling(0, 0);
        hold_request = LONG_HOLD;
        run_presses(60, 30);
        wait_drained();
        set_idling(45, 45);
        run_presses(20, 20);
        wait_drained();
    endtask

    initial begin
        reset_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_typical_periods();
        test_minimum_periods();
        test_zero_periods();
        test_maximum_periods();
        test_random_settings();
        test_backpressure();

        // Drain, then give a late extra beat time to show up.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (predicted_reports.size() != 0) begin
            $display("%0t: %0d predicted reports never arrived",
                     $time, predicted_reports.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("button_debounce_autorepeat_unit verification clean");
        end else begin
            $display("button_debounce_autorepeat_unit verification failed");
        end
        $finish;
    end

endmodule

### files.f
hdl/bdar_pkg.sv
hdl/bdar_div.sv
hdl/button_debounce_autorepeat_unit.sv
tb/sv/tb_top.sv
